>>> rtl/core/rcgpt_pkg.sv
// shared constants and types of the round chart grid pixel test
`default_nettype none

package rcgpt_pkg;

    localparam int COORD_BITS    = 10;
    localparam int RAD_BITS      = 9;
    localparam int MODE_BITS     = 2;
    localparam int COLOR_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // signed pixel offset and working width of the circle sums
    localparam int DW  = COORD_BITS + 1;
    localparam int SW  = 2 * COORD_BITS + 6;
    localparam int RSQ_BITS = 2 * RAD_BITS;

    // floor(v / 25) = (v * RECIP25) >> RECIP25_SHIFT, exact for v below 2^23
    localparam int RECIP25_BITS  = 24;
    localparam logic [RECIP25_BITS-1:0] RECIP25 = 24'd10737419;
    localparam int RECIP25_SHIFT = 28;
    localparam int RQ_IN_BITS    = RSQ_BITS + 4;
    localparam int RQ_PROD_BITS  = RQ_IN_BITS + RECIP25_BITS;

    // floor(v / 5) = (v * RECIP5) >> RECIP5_SHIFT, exact for v below 2^14
    localparam int RECIP5_BITS  = 12;
    localparam logic [RECIP5_BITS-1:0] RECIP5 = 12'd3277;
    localparam int RECIP5_SHIFT = 14;
    localparam int RK_BITS      = RAD_BITS + 2;
    localparam int TP_BITS      = RK_BITS + RECIP5_BITS;

    localparam int RINGS = 4;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE,
        MODE_POLAR,
        MODE_SMITH,
        MODE_SMITH_ADM
    } t_grid_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS,
        REG_MODE,
        REG_COLOR
    } t_cfg_reg;

    localparam logic [COORD_BITS-1:0] RST_CENTER_X = COORD_BITS'(160);
    localparam logic [COORD_BITS-1:0] RST_CENTER_Y = COORD_BITS'(120);
    localparam logic [RAD_BITS-1:0]   RST_RADIUS   = RAD_BITS'(100);
    localparam logic [COLOR_BITS-1:0] RST_COLOR    = '0;

endpackage

`default_nettype wire

>>> rtl/core/rcgpt_pix_if.sv
// pixel coordinate channel
`default_nettype none

interface rcgpt_pix_if;
    import rcgpt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rcgpt_res_if.sv
// grid test result channel
`default_nettype none

interface rcgpt_res_if;
    import rcgpt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  on_grid;
    logic [COLOR_BITS-1:0] draw_color;

    modport source (output valid, output on_grid, output draw_color, input ready);
    modport sink   (input valid, input on_grid, input draw_color, output ready);
endinterface

`default_nettype wire

>>> rtl/core/round_chart_grid_pixel_test_core.sv
// round chart grid pixel test: five stage pipeline from pixel to grid hit
`default_nettype none
//
//  channel   dir  handshake        payload
//  i_pix     in   valid / ready    pixel_x, pixel_y
//  o_res     out  valid / ready    on_grid, draw_color
//  i_cfg     in   i_cfg_we         i_cfg_idx, i_cfg_data
//
//  one pixel per clock unless a stalled output has filled the pipeline
//  stages: offset, products, sums and ring bounds, circle compares, output register
//  every stage moves on when the stage after it is empty or moving, so bubbles close up
//  and a stalled output only holds the pipeline once all five stages are full
//  synchronous active-low reset clears the stage valids and loads the register defaults

module round_chart_grid_pixel_test_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [rcgpt_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [rcgpt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    rcgpt_pix_if.sink                           i_pix,
    rcgpt_res_if.source                         o_res
);
    import rcgpt_pkg::*;

    // configuration
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [RAD_BITS-1:0]   r_rad;
    t_grid_mode            r_mode;
    logic [COLOR_BITS-1:0] r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= RST_CENTER_X;
            r_cy    <= RST_CENTER_Y;
            r_rad   <= RST_RADIUS;
            r_mode  <= MODE_NONE;
            r_color <= RST_COLOR;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_CENTER_X: r_cx    <= i_cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y: r_cy    <= i_cfg_data[COORD_BITS-1:0];
                REG_RADIUS:   r_rad   <= i_cfg_data[RAD_BITS-1:0];
                REG_MODE:     r_mode  <= t_grid_mode'(i_cfg_data[MODE_BITS-1:0]);
                REG_COLOR:    r_color <= i_cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // radius derived terms
    logic signed [SW-1:0] c_r, c_half, c_r3, c_th, c_q, c_tq;

    always_comb begin
        c_r    = $signed({{(SW-RAD_BITS){1'b0}}, r_rad});
        c_half = c_r >>> 1;
        c_r3   = c_r + (c_r <<< 1);
        c_th   = c_r3 >>> 1;
        c_q    = c_r >>> 2;
        c_tq   = c_r3 >>> 2;
    end

    // flow control
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r5_v || o_res.ready;
    assign rdy4 = !r4_v || rdy5;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign i_pix.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_pix.valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
        end
    end

    // stage 1: offset from the chart center
    logic signed [DW-1:0] n1_dx, n1_dy;
    logic signed [DW-1:0] r1_dx, r1_dy;

    always_comb begin
        n1_dx = $signed({1'b0, i_pix.pixel_x}) - $signed({1'b0, r_cx});
        n1_dy = $signed({1'b0, i_pix.pixel_y}) - $signed({1'b0, r_cy});
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_pix.valid) begin
            r1_dx <= n1_dx;
            r1_dy <= n1_dy;
        end
    end

    // stage 2: squares, radius products and ring tolerances
    logic signed [SW-1:0] dx_w, dy_w, ady_w;
    logic signed [SW-1:0] n2_x2, n2_y2, n2_rsq, n2_rx, n2_rya, n2_hx, n2_tx;
    logic [RAD_BITS-1:0]  n2_tol [RINGS];
    logic                 n2_xz, n2_yz, n2_diag;
    logic [1:0]           n2_xpos, n2_xgeh;

    logic signed [SW-1:0] r2_x2, r2_y2, r2_rsq, r2_rx, r2_rya, r2_hx, r2_tx;
    logic [RAD_BITS-1:0]  r2_tol [RINGS];
    logic                 r2_xz, r2_yz, r2_diag;
    logic [1:0]           r2_xpos, r2_xgeh;

    always_comb begin
        logic [RK_BITS-1:0] rk;
        logic [TP_BITS-1:0] tp;
        dx_w   = SW'(r1_dx);
        dy_w   = SW'(r1_dy);
        ady_w  = dy_w[SW-1] ? -dy_w : dy_w;
        n2_x2  = dx_w * dx_w;
        n2_y2  = dy_w * dy_w;
        n2_rsq = c_r * c_r;
        n2_rx  = c_r * dx_w;
        n2_rya = c_r * ady_w;
        n2_hx  = c_half * dx_w;
        n2_tx  = c_th * dx_w;
        for (int k = 0; k < RINGS; k++) begin
            rk = RK_BITS'(r_rad) * RK_BITS'(k + 1);
            tp = TP_BITS'(rk) * TP_BITS'(RECIP5);
            n2_tol[k] = RAD_BITS'(tp >> RECIP5_SHIFT);
        end
        n2_xz      = (r1_dx == '0);
        n2_yz      = (r1_dy == '0);
        n2_diag    = (r1_dx == r1_dy) || (r1_dx == -r1_dy);
        // index 0 is the pixel as given, index 1 the pixel mirrored about the center
        n2_xpos[0] = !dx_w[SW-1];
        n2_xpos[1] = dx_w[SW-1] || n2_xz;
        n2_xgeh[0] = (dx_w >= c_half);
        n2_xgeh[1] = (-dx_w >= c_half);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_v) begin
            r2_x2   <= n2_x2;
            r2_y2   <= n2_y2;
            r2_rsq  <= n2_rsq;
            r2_rx   <= n2_rx;
            r2_rya  <= n2_rya;
            r2_hx   <= n2_hx;
            r2_tx   <= n2_tx;
            r2_tol  <= n2_tol;
            r2_xz   <= n2_xz;
            r2_yz   <= n2_yz;
            r2_diag <= n2_diag;
            r2_xpos <= n2_xpos;
            r2_xgeh <= n2_xgeh;
        end
    end

    // stage 3: squared distance, squared ring radii and the constant part of each arc test
    logic [RSQ_BITS-1:0]     rsq_u;
    logic signed [SW-1:0]    n3_d2, n3_hi, n3_lo;
    logic signed [SW-1:0]    n3_ring [RINGS];
    logic signed [SW-1:0]    n3_ba [2], n3_bb [2], n3_bc [2];
    logic signed [SW-1:0]    n3_bd [2], n3_be [2], n3_bf [2];

    logic signed [SW-1:0]    r3_d2, r3_hi, r3_lo;
    logic signed [SW-1:0]    r3_ring [RINGS];
    logic [RAD_BITS-1:0]     r3_tol [RINGS];
    logic signed [SW-1:0]    r3_ba [2], r3_bb [2], r3_bc [2];
    logic signed [SW-1:0]    r3_bd [2], r3_be [2], r3_bf [2];
    logic                    r3_xz, r3_yz, r3_diag;
    logic [1:0]              r3_xpos, r3_xgeh;

    always_comb begin
        logic [RQ_IN_BITS-1:0]   rv;
        logic [RQ_PROD_BITS-1:0] rp;
        logic signed [SW-1:0]    rxs, txs, hxs, rsq_h;
        rsq_u = r2_rsq[RSQ_BITS-1:0];
        rsq_h = r2_rsq >>> 1;
        n3_d2 = r2_x2 + r2_y2;
        n3_hi = r2_rsq + c_r;
        n3_lo = r2_rsq - c_r;
        for (int k = 0; k < RINGS; k++) begin
            rv = RQ_IN_BITS'(rsq_u) * RQ_IN_BITS'((k + 1) * (k + 1));
            rp = RQ_PROD_BITS'(rv) * RQ_PROD_BITS'(RECIP25);
            n3_ring[k] = $signed(SW'(rp >> RECIP25_SHIFT));
        end
        for (int m = 0; m < 2; m++) begin
            rxs = (m == 0) ? r2_rx : -r2_rx;
            txs = (m == 0) ? r2_tx : -r2_tx;
            hxs = (m == 0) ? r2_hx : -r2_hx;
            n3_ba[m] = r2_rsq + c_half - (rxs <<< 1) - r2_rya;
            n3_bb[m] = rsq_h + c_q - txs;
            n3_bc[m] = r2_rsq + c_r - (rxs <<< 1) - (r2_rya <<< 1);
            n3_bd[m] = c_half - rxs;
            n3_be[m] = r2_rsq + (c_r <<< 1) - (rxs <<< 1) - (r2_rya <<< 2);
            n3_bf[m] = c_tq - rsq_h - hxs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_v) begin
            r3_d2   <= n3_d2;
            r3_hi   <= n3_hi;
            r3_lo   <= n3_lo;
            r3_ring <= n3_ring;
            r3_tol  <= r2_tol;
            r3_ba   <= n3_ba;
            r3_bb   <= n3_bb;
            r3_bc   <= n3_bc;
            r3_bd   <= n3_bd;
            r3_be   <= n3_be;
            r3_bf   <= n3_bf;
            r3_xz   <= r2_xz;
            r3_yz   <= r2_yz;
            r3_diag <= r2_diag;
            r3_xpos <= r2_xpos;
            r3_xgeh <= r2_xgeh;
        end
    end

    // stage 4: circle compares and grid decision
    logic n4_hit;
    logic n4_out, n4_onc, n4_polar;
    logic [1:0] n4_smith;

    always_comb begin
        logic signed [SW-1:0] tol_s, da, db, dc, dd, de, df;
        logic                 done, ring_hit, arcs;
        n4_out   = (r3_d2 > r3_hi);
        n4_onc   = (r3_d2 > r3_lo);

        // rings from the inside out; falling short of a ring ends the search
        done     = 1'b0;
        ring_hit = 1'b0;
        for (int k = 0; k < RINGS; k++) begin
            tol_s = $signed({{(SW-RAD_BITS){1'b0}}, r3_tol[k]});
            if (!done) begin
                if (r3_d2 < r3_ring[k] - tol_s) begin
                    done = 1'b1;
                end else if (r3_d2 < r3_ring[k] + tol_s) begin
                    ring_hit = 1'b1;
                    done     = 1'b1;
                end else if (k == 1 && r3_diag) begin
                    ring_hit = 1'b1;
                    done     = 1'b1;
                end
            end
        end
        n4_polar = !n4_out && (n4_onc || r3_xz || r3_yz || ring_hit);

        for (int m = 0; m < 2; m++) begin
            da = r3_d2 + r3_ba[m];
            db = r3_d2 + r3_bb[m];
            dc = r3_d2 + r3_bc[m];
            dd = r3_d2 + r3_bd[m];
            de = r3_d2 + r3_be[m];
            df = r3_d2 + r3_bf[m];
            arcs = (r3_xpos[m] && ((r3_xgeh[m] && (((da >= -c_r) && (da <= c_r))
                                                   || (!db[SW-1] && (db <= c_half))))
                                   || ((dc >= -(c_r <<< 1)) && (dc <= (c_r <<< 1)))
                                   || (!dd[SW-1] && (dd <= c_r))))
                   || ((de >= -(c_r <<< 2)) && (de <= (c_r <<< 2)))
                   || ((df >= -c_th) && (df <= c_th));
            n4_smith[m] = !n4_out && (n4_onc || r3_yz || arcs);
        end

        case (r_mode)
            MODE_POLAR:     n4_hit = n4_polar;
            MODE_SMITH:     n4_hit = n4_smith[0];
            MODE_SMITH_ADM: n4_hit = n4_smith[0] || n4_smith[1];
            default:        n4_hit = 1'b0;
        endcase
    end

    logic r4_hit;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_v) begin
            r4_hit <= n4_hit;
        end
    end

    // stage 5: output register
    logic                  r5_hit;
    logic [COLOR_BITS-1:0] r5_color;

    always_ff @(posedge i_clk) begin
        if (rdy5 && r4_v) begin
            r5_hit   <= r4_hit;
            r5_color <= r4_hit ? r_color : '0;
        end
    end

    assign o_res.valid      = r5_v;
    assign o_res.on_grid    = r5_hit;
    assign o_res.draw_color = r5_color;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r1_v && r2_v && r3_v && r4_v && r5_v))
        else $error("input held off with a bubble in the pipeline");

    a_output_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && !r5_v) |=> r5_v)
        else $error("empty output register did not take the waiting result");

    a_stage4_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && rdy4) |=> r4_v)
        else $error("item lost between compare stages");

    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.on_grid) |-> (o_res.draw_color == '0))
        else $error("color given for a pixel off the grid");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench of the round chart grid pixel test core
`timescale 1ns / 100ps

module testbench;
    import rcgpt_pkg::*;

    localparam int unsigned LIMIT     = 500000;
    localparam int unsigned HOLD_AT   = 60;
    localparam int unsigned HOLD_LEN  = 150;
    localparam int          PHASES    = 6;
    localparam int          PHASE_PIX = 67;
    localparam int          TAIL      = 20;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  on_grid;
        logic [COLOR_BITS-1:0] draw_color;
    } grid_pixel_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    rcgpt_pix_if pix_ch ();
    rcgpt_res_if res_ch ();

    round_chart_grid_pixel_test_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    // register copy seen by the grid predictor
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    t_grid_mode            mode_reg;
    logic [COLOR_BITS-1:0] color_reg;

    pixel_t      pending_pixels[$];
    grid_pixel_t expected_pixels[$];

    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned err_count       = 0;
    int unsigned cycle_count     = 0;
    int unsigned pix_gap         = 0;
    int unsigned res_stall       = 0;
    int unsigned hold_left       = 0;
    bit          hold_done       = 1'b0;
    bit          no_idle         = 1'b0;
    logic        pix_fire        = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit polar_on(input longint x, input longint y, input longint r);
        longint d2;
        longint rsq;
        longint ringsq;
        longint tol;
        longint k;
        d2  = x * x + y * y;
        rsq = r * r;
        if (d2 > rsq + r) return 1'b0;
        if (d2 > rsq - r) return 1'b1;
        if (x == 0 || y == 0) return 1'b1;
        for (k = 1; k <= RINGS; k++) begin
            ringsq = (rsq * k * k) / 25;
            tol    = (r * k) / 5;
            if (d2 < ringsq - tol) return 1'b0;
            if (d2 < ringsq + tol) return 1'b1;
            // diagonals only run outside the second ring
            if (k == 2 && (x == y || x == -y)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit smith_on(input longint x, input longint y, input longint r);
        longint d2;
        longint rsq;
        longint ya;
        longint half;
        longint d;
        d2   = x * x + y * y;
        rsq  = r * r;
        ya   = mag(y);
        half = r / 2;
        if (d2 > rsq + r) return 1'b0;
        if (d2 > rsq - r) return 1'b1;
        if (y == 0) return 1'b1;
        if (x >= 0) begin
            if (x >= half) begin
                d = d2 - (2 * r * x + r * ya) + rsq + half;
                if (mag(d) <= r) return 1'b1;
                d = d2 - ((3 * r) / 2) * x + rsq / 2 + r / 4;
                if (d >= 0 && d <= half) return 1'b1;
            end
            d = d2 - (2 * r * x + 2 * r * ya) + rsq + r;
            if (mag(d) <= 2 * r) return 1'b1;
            d = d2 - r * x + half;
            if (d >= 0 && d <= r) return 1'b1;
        end
        d = d2 - (2 * r * x + 4 * r * ya) + rsq + 2 * r;
        if (mag(d) <= 4 * r) return 1'b1;
        d = d2 - half * x - rsq / 2 + (3 * r) / 4;
        return mag(d) <= (3 * r) / 2;
    endfunction

    function automatic grid_pixel_t grid_lookup(input logic [COORD_BITS-1:0] px,
                                                input logic [COORD_BITS-1:0] py);
        grid_pixel_t verdict;
        longint      dx;
        longint      dy;
        longint      r;
        bit          hit;
        dx = longint'(px) - longint'(cx_reg);
        dy = longint'(py) - longint'(cy_reg);
        r  = longint'(rad_reg);
        case (mode_reg)
            MODE_POLAR:     hit = polar_on(dx, dy, r);
            MODE_SMITH:     hit = smith_on(dx, dy, r);
            MODE_SMITH_ADM: hit = smith_on(dx, dy, r) || smith_on(-dx, dy, r);
            default:        hit = 1'b0;
        endcase
        verdict.px         = px;
        verdict.py         = py;
        verdict.on_grid    = hit;
        verdict.draw_color = hit ? color_reg : '0;
        return verdict;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_CENTER_X: cx_reg    = data[COORD_BITS-1:0];
            REG_CENTER_Y: cy_reg    = data[COORD_BITS-1:0];
            REG_RADIUS:   rad_reg   = data[RAD_BITS-1:0];
            REG_MODE:     mode_reg  = t_grid_mode'(data[MODE_BITS-1:0]);
            REG_COLOR:    color_reg = data[COLOR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_pixel(input int x, input int y);
        pixel_t p;
        p.x = COORD_BITS'(x);
        p.y = COORD_BITS'(y);
        pending_pixels.push_back(p);
        pixels_queued++;
    endtask

    // every pixel gives one result, so idle means every queued pixel is accepted and the expectation queue is empty
    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || expected_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    // pixel driver
    always @(negedge i_clk) begin
        pixel_t nxt;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_fire) begin
            if (pix_gap != 0) begin
                pix_gap      <= pix_gap - 1;
                pix_ch.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                nxt = pending_pixels.pop_front();
                pix_ch.valid   <= 1'b1;
                pix_ch.pixel_x <= nxt.x;
                pix_ch.pixel_y <= nxt.y;
                pix_gap        <= no_idle ? 0 : idle_len();
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the pipeline fills and stalls its input
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && pixels_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
        end else if (res_stall != 0) begin
            res_stall    <= res_stall - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0)
                res_stall <= idle_len();
        end
    end

    // monitor: check result transfers, then predict for pixel transfers
    always @(posedge i_clk) begin
        grid_pixel_t want;
        pix_fire <= i_rst_n && pix_ch.valid && pix_ch.ready;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    log_error($sformatf("result with nothing pending: on_grid %b color %h",
                                        res_ch.on_grid, res_ch.draw_color));
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_ch.on_grid !== want.on_grid)
                        log_error($sformatf("pixel (%0d,%0d): on_grid %b, want %b",
                                            want.px, want.py, res_ch.on_grid, want.on_grid));
                    if (res_ch.draw_color !== want.draw_color)
                        log_error($sformatf("pixel (%0d,%0d): draw_color %h, want %h",
                                            want.px, want.py, res_ch.draw_color,
                                            want.draw_color));
                end
            end
            if (pix_ch.valid && pix_ch.ready) begin
                expected_pixels.push_back(grid_lookup(pix_ch.pixel_x, pix_ch.pixel_y));
                pixels_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int                    ph;
        int                    n;
        int                    span;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [RAD_BITS-1:0]   rad;
        t_grid_mode            mode;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        res_ch.ready   = 1'b0;
        cx_reg         = RST_CENTER_X;
        cy_reg         = RST_CENTER_Y;
        rad_reg        = RST_RADIUS;
        mode_reg       = MODE_NONE;
        color_reg      = RST_COLOR;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no grid at all
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(160, 120);
        wait_idle();

        // polar on the reset center and radius
        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_POLAR));
        write_reg(REG_COLOR, 16'hF800);
        queue_pixel(160, 120);
        queue_pixel(260, 120);
        queue_pixel(261, 120);
        queue_pixel(200, 120);
        queue_pixel(180, 121);
        queue_pixel(200, 160);
        queue_pixel(230, 190);
        queue_pixel(60, 20);
        wait_idle();

        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_SMITH));
        write_reg(REG_COLOR, 16'h07E0);
        queue_pixel(160, 120);
        queue_pixel(210, 120);
        queue_pixel(250, 170);
        queue_pixel(240, 100);
        queue_pixel(110, 150);
        queue_pixel(200, 40);
        queue_pixel(259, 122);
        wait_idle();

        // largest offsets and largest radius, mirrored admittance arcs
        write_reg(REG_CENTER_X, 16'd0);
        write_reg(REG_CENTER_Y, 16'd0);
        write_reg(REG_RADIUS, 16'd511);
        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_SMITH_ADM));
        write_reg(REG_COLOR, 16'hFFFF);
        queue_pixel(0, 0);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        queue_pixel(300, 300);
        queue_pixel(511, 0);
        wait_idle();

        // zero radius: only the center point remains
        write_reg(REG_CENTER_X, 16'd1023);
        write_reg(REG_CENTER_Y, 16'd1023);
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_MODE, CFG_DATA_BITS'(MODE_POLAR));
        queue_pixel(1023, 1023);
        queue_pixel(1022, 1023);
        queue_pixel(0, 0);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            no_idle <= (ph == 3);
            cx = (ph == 1) ? '0 : (ph == 4) ? '1 : COORD_BITS'($urandom);
            cy = (ph == 1) ? '1 : (ph == 4) ? '0 : COORD_BITS'($urandom);
            case (ph)
                0:       rad = RAD_BITS'($urandom_range(4, 160));
                1:       rad = '1;
                2:       rad = RAD_BITS'($urandom_range(0, 3));
                3:       rad = RAD_BITS'($urandom_range(20, 120));
                4:       rad = RAD_BITS'($urandom);
                default: rad = RAD_BITS'($urandom_range(4, 80));
            endcase
            case (ph)
                0, 2:    mode = MODE_POLAR;
                3, 4:    mode = MODE_SMITH_ADM;
                default: mode = MODE_SMITH;
            endcase
            // upper data bits carry noise that the block must drop
            write_reg(REG_CENTER_X, {6'($urandom), cx});
            write_reg(REG_CENTER_Y, {6'($urandom), cy});
            write_reg(REG_RADIUS, {7'($urandom), rad});
            write_reg(REG_MODE, {14'($urandom), mode});
            write_reg(REG_COLOR, 16'($urandom));
            span = int'(rad_reg) + 8;
            for (n = 0; n < PHASE_PIX; n++) begin
                if ($urandom_range(0, 3) != 0)
                    queue_pixel(int'(cx_reg) + $urandom_range(0, 2 * span) - span,
                                int'(cy_reg) + $urandom_range(0, 2 * span) - span);
                else
                    queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end

        wait_idle();
        repeat (TAIL) @(negedge i_clk);
        if (expected_pixels.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_pixels.size()));
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> round_chart_grid_pixel_test_core.f
rtl/core/rcgpt_pkg.sv
rtl/core/rcgpt_pix_if.sv
rtl/core/rcgpt_res_if.sv
rtl/core/round_chart_grid_pixel_test_core.sv
dv/testbench.sv
